// ===== hw/rtl/bbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbsf_pkg
// Types and constants shared by the bounded byte stream FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbsf_pkg;

    localparam int CNT_W  = 13;
    localparam int BYTE_W = 8;
    localparam int TOT_W  = 64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PEEK  = 2'd1,
        OP_POP   = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_RESP = 2'd2
    } state_t;

    typedef enum logic {
        REG_CAPACITY_LIMIT = 1'b0,
        REG_UNUSED         = 1'b1
    } reg_idx_t;

    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  amount;
    } item_t;

    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic [CNT_W-1:0]  popped_count;
        logic [CNT_W-1:0]  occupancy;
        logic [CNT_W-1:0]  room_left;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
        logic              ended;
        logic              at_eof;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbsf_ctrl
// Sequencer: take an operation, run its execute cycle, present its result.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsf_ctrl
    import bbsf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output ctrl_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbsf_datapath.sv =====
// ----------------------------------------------------------------------------
// bbsf_datapath
// Byte store, head pointer, fill count, totals and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsf_datapath
    import bbsf_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctrl_cmd_t        cmd,
    input  wire item_t            item,
    input  wire logic [CNT_W-1:0] cap_limit,
    output result_t               result
);

    localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int CAPMAX = (DEPTH > 8191) ? 8191 : DEPTH;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPMAX);
    localparam logic [SW-1:0]    SDEPTH  = SW'(DEPTH);

    logic [BYTE_W-1:0] store_mem [DEPTH];

    item_t             item_reg;
    result_t           res_reg;
    result_t           res_next;
    logic [BYTE_W-1:0] rd_byte_reg;
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     head_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [TOT_W-1:0]  wtot_reg;
    logic [TOT_W-1:0]  wtot_next;
    logic [TOT_W-1:0]  rtot_reg;
    logic [TOT_W-1:0]  rtot_next;
    logic              ended_reg;
    logic              ended_next;

    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  popped;
    logic [CNT_W-1:0]  offset;
    logic [SW-1:0]     sum;
    logic [SW-1:0]     slot_wide;
    logic [PW-1:0]     slot;
    logic              wr_en;
    logic              peek_ok;
    logic              accepted;

    assign cap_eff = (cap_limit > CAP_MAX) ? CAP_MAX : cap_limit;
    assign popped  = (item_reg.amount < fill_reg) ? item_reg.amount : fill_reg;

    always_comb
    begin
        unique case (item_reg.operation)
            OP_WRITE: offset = fill_reg;
            OP_PEEK:  offset = item_reg.amount;
            OP_POP:   offset = popped;
            OP_END:   offset = fill_reg;
        endcase
    end

    assign sum       = SW'(head_reg) + SW'(offset);
    assign slot_wide = (sum >= SDEPTH) ? (sum - SDEPTH) : sum;
    assign slot      = slot_wide[PW-1:0];

    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        wtot_next  = wtot_reg;
        rtot_next  = rtot_reg;
        ended_next = ended_reg;
        wr_en      = 1'b0;
        peek_ok    = 1'b0;
        accepted   = 1'b0;
        unique case (item_reg.operation)
            OP_WRITE:
            begin
                if (fill_reg < cap_eff)
                begin
                    wr_en     = 1'b1;
                    accepted  = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    wtot_next = wtot_reg + 1'b1;
                end
            end
            OP_PEEK:
            begin
                peek_ok = (item_reg.amount < fill_reg);
            end
            OP_POP:
            begin
                head_next = slot;
                fill_next = fill_reg - popped;
                rtot_next = rtot_reg + TOT_W'(popped);
            end
            OP_END:
            begin
                ended_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res_next               = '0;
        res_next.accepted      = accepted;
        res_next.read_valid    = peek_ok;
        res_next.popped_count  = (item_reg.operation == OP_POP) ? popped : '0;
        res_next.occupancy     = fill_next;
        res_next.room_left     = (cap_eff > fill_next) ? (cap_eff - fill_next) : '0;
        res_next.total_written = wtot_next;
        res_next.total_read    = rtot_next;
        res_next.ended         = ended_next;
        res_next.at_eof        = (fill_next == '0) && ended_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            store_mem[slot] <= item_reg.data_byte;
        end
        if (cmd.exec && peek_ok)
        begin
            rd_byte_reg <= store_mem[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            fill_reg  <= '0;
            wtot_reg  <= '0;
            rtot_reg  <= '0;
            ended_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            wtot_reg  <= wtot_next;
            rtot_reg  <= rtot_next;
            ended_reg <= ended_next;
        end
    end

    always_comb
    begin
        result           = res_reg;
        result.read_byte = res_reg.read_valid ? rd_byte_reg : '0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_byte_stream_fifo.sv =====
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo
// Byte FIFO with a programmable capacity; write, peek, pop and end commands.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. It runs in the
// execute state (single-port byte store with a registered read), and its
// result sits on the result port in the following cycle with done high; the
// next start is taken in the done cycle. done is a one-cycle strobe: the
// receiver cannot stall, so sample result whenever done is high.
// capacity_limit sits at byte address 0 of the APB port; write it only
// while no operation is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_byte_stream_fifo
    import bbsf_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ctrl_cmd_t        cmd;
    logic [CNT_W-1:0] cap_reg;
    reg_idx_t         reg_idx;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_CAPACITY_LIMIT) ? 32'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY_LIMIT))
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    bbsf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bbsf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cap_limit (cap_reg),
        .result    (result)
    );

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not enter execute");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle not followed by a result transfer");

    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({result.accepted, result.read_valid,
                           result.popped_count != '0}))
        else $error("result reports more than one effect");

    a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.at_eof |-> result.ended && (result.occupancy == '0))
        else $error("eof flagged while not empty or not ended");

endmodule

`default_nettype wire
